>>> rtl/core/u8wrap_pkg.sv
// ----------------------------------------------------------------------------
// u8wrap_pkg
// Shared types, constants and helpers for the UTF-8 decoder with line wrap.
// ----------------------------------------------------------------------------
package u8wrap_pkg;

    localparam int COORD_WIDTH = 11;
    localparam int FONT_WIDTH  = 7;
    localparam int CP_WIDTH    = 21;
    localparam int BYTE_WIDTH  = 8;
    localparam int CFG_IDX_W   = 3;

    localparam int ASCII_ADVANCE = 7;
    localparam int LINE_EXTRA    = 6;
    localparam int WIDE_EXTRA    = 2;
    localparam int ASCII_BASE    = 8;

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [COORD_WIDTH:0]   coord_sum_t;
    typedef logic [FONT_WIDTH-1:0]  font_t;
    typedef logic [CP_WIDTH-1:0]    cp_t;

    localparam cp_t CP_QUESTION = cp_t'(8'h3F);
    localparam cp_t CP_NEWLINE  = cp_t'(8'h0A);
    localparam cp_t CP_SPACE    = cp_t'(8'h20);
    localparam cp_t CP_TILDE    = cp_t'(8'h7E);

    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_WIDE  = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X   = 3'd0,
        REG_START_Y   = 3'd1,
        REG_MAX_X     = 3'd2,
        REG_MAX_Y     = 3'd3,
        REG_FONT_SIZE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        kind_t  kind;
        cp_t    code_point;
        coord_t pos_x;
        coord_t pos_y;
        logic   last_of_run;
    } result_t;

    function automatic coord_t sat_coord(coord_sum_t v);
        return v[COORD_WIDTH] ? '1 : v[COORD_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/u8wrap_if.sv
// ----------------------------------------------------------------------------
// u8wrap_if
// Valid/ready channels for text bytes in and placed glyphs out.
// ----------------------------------------------------------------------------
interface u8wrap_text_if;
    import u8wrap_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [BYTE_WIDTH-1:0] text_byte;
    logic                  final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface u8wrap_glyph_if;
    import u8wrap_pkg::*;

    logic   valid;
    logic   ready;
    kind_t  kind;
    cp_t    code_point;
    coord_t pos_x;
    coord_t pos_y;
    logic   last_of_run;

    modport source (output valid, output kind, output code_point, output pos_x,
                    output pos_y, output last_of_run, input ready);
    modport sink   (input valid, input kind, input code_point, input pos_x,
                    input pos_y, input last_of_run, output ready);
endinterface

>>> rtl/core/utf8_decode_text_wrap_top.sv
// ----------------------------------------------------------------------------
// utf8_decode_text_wrap_top
// UTF-8 decoder that lays characters out in a wrapping text box.
// ----------------------------------------------------------------------------
// Text bytes arrive on the text channel and placed glyphs leave on the glyph
// channel; both use a valid/ready handshake. Each byte is decoded and placed
// in the cycle it is accepted, and its results are written into a four-entry
// result queue, so when the queue is empty the first result is shown in the
// cycle after the byte. The block takes one byte per clock while the queue has
// room. A byte gives zero, one or two results; the byte with final_byte adds
// an end-of-text request carrying the bottom y. Text is taken while the queue
// has room for two more results, so a stalled receiver blocks input only once
// it holds three results, which holds back a stream of two-result bytes.
// The configuration port writes box limits and font size between texts; a
// write to start_x or start_y also moves the cursor. Reset clears the queue
// and the decoder, loads default limits and puts the cursor at the origin.
// After each end-of-text request the decoder and cursor return to their
// starting state for the next text.
// ----------------------------------------------------------------------------
module utf8_decode_text_wrap_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [u8wrap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [u8wrap_pkg::COORD_WIDTH-1:0] cfg_wr_data,
    u8wrap_text_if.sink                        text,
    u8wrap_glyph_if.source                     glyph
);
    import u8wrap_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    coord_t start_x_reg, start_y_reg, max_x_reg, max_y_reg;
    font_t  font_size_reg;

    logic [1:0] pend_reg, pend_next;
    cp_t        pv_reg, pv_next;
    coord_t     cursor_x_reg, cursor_x_next;
    coord_t     cursor_y_reg, cursor_y_next;
    logic       stopped_reg, stopped_next;

    result_t             queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    logic       accept, pop;
    logic       place_en, emit, end_en;
    cp_t        place_cp;
    result_t    glyph_item, end_item, entry0, entry1;
    logic [1:0] push_n;

    assign accept = text.valid && text.ready;
    assign pop    = glyph.valid && glyph.ready;
    assign text.ready  = count_reg <= (QPTR_W+1)'(QDEPTH - 2);
    assign glyph.valid = count_reg != '0;

    assign glyph.kind        = queue_reg[rd_ptr_reg].kind;
    assign glyph.code_point  = queue_reg[rd_ptr_reg].code_point;
    assign glyph.pos_x       = queue_reg[rd_ptr_reg].pos_x;
    assign glyph.pos_y       = queue_reg[rd_ptr_reg].pos_y;
    assign glyph.last_of_run = queue_reg[rd_ptr_reg].last_of_run;

    always_comb
    begin
        logic [BYTE_WIDTH-1:0] b;
        logic                  ascii;
        logic [7:0]            adv;
        coord_sum_t            cy_fs, nl_sum, nl_fs, cx_adv, sx_adv, y_adj;
        coord_t                nl_y, base_x, base_y, y_out;
        font_t                 y_off;
        logic                  wrap;

        b         = text.text_byte;
        pend_next = pend_reg;
        pv_next   = pv_reg;
        place_en  = 1'b0;
        place_cp  = CP_QUESTION;

        if (pend_reg == 2'd0)
        begin
            if (!b[7])
            begin
                place_en = 1'b1;
                place_cp = cp_t'(b);
            end
            else if ((b & 8'hE0) == 8'hC0)
            begin
                pend_next = 2'd1;
                pv_next   = cp_t'(b & 8'h1F);
            end
            else if ((b & 8'hF0) == 8'hE0)
            begin
                pend_next = 2'd2;
                pv_next   = cp_t'(b & 8'h0F);
            end
            else if ((b & 8'hF8) == 8'hF0)
            begin
                pend_next = 2'd3;
                pv_next   = cp_t'(b & 8'h07);
            end
            else
            begin
                place_en = 1'b1;
            end
        end
        else if ((b & 8'hC0) != 8'h80)
        begin
            pend_next = 2'd0;
            pv_next   = '0;
            place_en  = 1'b1;
        end
        else
        begin
            pv_next   = {pv_reg[CP_WIDTH-7:0], b[5:0]};
            pend_next = pend_reg - 2'd1;
            if (pend_next == 2'd0)
            begin
                place_en = 1'b1;
                place_cp = pv_next;
                pv_next  = '0;
            end
        end

        end_en = text.final_byte;
        if (end_en && pend_next != 2'd0)
        begin
            place_en = 1'b1;
            place_cp = CP_QUESTION;
        end

        ascii  = place_cp inside {[CP_SPACE:CP_TILDE]};
        adv    = ascii ? 8'(ASCII_ADVANCE) : 8'(font_size_reg) + 8'(WIDE_EXTRA);
        cy_fs  = coord_sum_t'(cursor_y_reg) + coord_sum_t'(font_size_reg);
        nl_sum = cy_fs + coord_sum_t'(LINE_EXTRA);
        nl_y   = sat_coord(nl_sum);
        nl_fs  = coord_sum_t'(nl_y) + coord_sum_t'(font_size_reg);
        cx_adv = coord_sum_t'(cursor_x_reg) + coord_sum_t'(adv);
        sx_adv = coord_sum_t'(start_x_reg) + coord_sum_t'(adv);
        wrap   = cx_adv > coord_sum_t'(max_x_reg);
        base_x = wrap ? start_x_reg : cursor_x_reg;
        base_y = wrap ? nl_y : cursor_y_reg;
        y_off  = (ascii && font_size_reg >= font_t'(ASCII_BASE))
                 ? (font_size_reg - font_t'(ASCII_BASE)) >> 1 : '0;
        y_adj  = coord_sum_t'(base_y) + coord_sum_t'(y_off);
        y_out  = sat_coord(y_adj);

        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        stopped_next  = stopped_reg;
        emit          = 1'b0;

        if (place_en && !stopped_reg)
        begin
            if (cy_fs > coord_sum_t'(max_y_reg))
            begin
                stopped_next = 1'b1;
            end
            else if (place_cp == CP_NEWLINE)
            begin
                cursor_x_next = start_x_reg;
                cursor_y_next = nl_y;
            end
            else if (wrap && nl_fs > coord_sum_t'(max_y_reg))
            begin
                cursor_x_next = start_x_reg;
                cursor_y_next = nl_y;
                stopped_next  = 1'b1;
            end
            else
            begin
                emit          = 1'b1;
                cursor_y_next = base_y;
                cursor_x_next = sat_coord(wrap ? sx_adv : cx_adv);
            end
        end

        glyph_item.kind        = ascii ? KIND_ASCII : KIND_WIDE;
        glyph_item.code_point  = place_cp;
        glyph_item.pos_x       = base_x;
        glyph_item.pos_y       = y_out;
        glyph_item.last_of_run = !end_en;

        end_item.kind          = KIND_END;
        end_item.code_point    = '0;
        end_item.pos_x         = '0;
        end_item.pos_y         = sat_coord((cursor_y_next == nl_y && cursor_y_next != cursor_y_reg)
                                           ? nl_fs
                                           : coord_sum_t'(cursor_y_next)
                                             + coord_sum_t'(font_size_reg));
        end_item.last_of_run   = 1'b1;

        if (end_en)
        begin
            pend_next     = 2'd0;
            pv_next       = '0;
            cursor_x_next = start_x_reg;
            cursor_y_next = start_y_reg;
            stopped_next  = 1'b0;
        end

        entry0 = emit ? glyph_item : end_item;
        entry1 = end_item;
        push_n = 2'(emit) + 2'(end_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            max_x_reg     <= '1;
            max_y_reg     <= '1;
            font_size_reg <= font_t'(16);
            pend_reg      <= '0;
            pv_reg        <= '0;
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            stopped_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START_X:
                begin
                    start_x_reg  <= cfg_wr_data;
                    cursor_x_reg <= cfg_wr_data;
                end
                REG_START_Y:
                begin
                    start_y_reg  <= cfg_wr_data;
                    cursor_y_reg <= cfg_wr_data;
                end
                REG_MAX_X:     max_x_reg     <= cfg_wr_data;
                REG_MAX_Y:     max_y_reg     <= cfg_wr_data;
                REG_FONT_SIZE: font_size_reg <= cfg_wr_data[FONT_WIDTH-1:0];
                default:       ;
            endcase
        end
        else if (accept)
        begin
            pend_reg     <= pend_next;
            pv_reg       <= pv_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            stopped_reg  <= stopped_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (accept ? (QPTR_W+1)'(push_n) : '0)
                         - (QPTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= entry0;
        end
        if (accept && push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= entry1;
        end
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("result queue over capacity");

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        glyph.valid && glyph.kind == KIND_END |->
            glyph.code_point == '0 && glyph.pos_x == '0 && glyph.last_of_run)
        else $error("end-of-text request with stray fields");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        glyph.valid && !glyph.last_of_run |-> glyph.kind != KIND_END)
        else $error("end-of-text request not last of its run");

    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.final_byte && !cfg_wr_en |=>
            cursor_x_reg == start_x_reg && cursor_y_reg == start_y_reg
            && pend_reg == 2'd0 && !stopped_reg)
        else $error("state not restored after end of text");

endmodule

>>> bench/glyph_layout_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_layout_checker
// Watches the text and glyph channels of the UTF-8 text wrap block, works out
// the placed glyphs that each accepted text request must cause, and compares
// every glyph request that leaves the block with the oldest one still waiting.
// ----------------------------------------------------------------------------
module glyph_layout_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [u8wrap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [u8wrap_pkg::COORD_WIDTH-1:0] cfg_wr_data,
    u8wrap_text_if                             text,
    u8wrap_glyph_if                            glyph,
    output int unsigned                        fail_count,
    output int unsigned                        pending_results
);
    import u8wrap_pkg::*;

    localparam int   COORD_TOP  = (1 << COORD_WIDTH) - 1;
    localparam int   FONT_RESET = 16;

    coord_t     left_edge;
    coord_t     top_edge;
    coord_t     right_limit;
    coord_t     bottom_limit;
    font_t      glyph_size;

    logic [1:0] cont_left;
    cp_t        cp_accum;
    coord_t     cur_x;
    coord_t     cur_y;
    logic       layout_halted;

    result_t    expected_glyphs [$];
    result_t    byte_results [$];
    result_t    seen;
    result_t    oldest;

    function automatic coord_t clamp_coord(int value);
        return (value > COORD_TOP) ? coord_t'(COORD_TOP) : coord_t'(value);
    endfunction

    function automatic bit box_overflow();
        return int'(cur_y) + int'(glyph_size) > int'(bottom_limit);
    endfunction

    task automatic advance_line();
        cur_x = left_edge;
        cur_y = clamp_coord(int'(cur_y) + int'(glyph_size) + LINE_EXTRA);
    endtask

    task automatic place_char(input cp_t cp);
        bit     printable;
        int     advance;
        coord_t top;
        kind_t  glyph_kind;
        if (layout_halted)
            return;
        if (box_overflow())
        begin
            layout_halted = 1'b1;
            return;
        end
        if (cp == CP_NEWLINE)
        begin
            advance_line();
            return;
        end
        printable = (cp >= CP_SPACE) && (cp <= CP_TILDE);
        advance   = printable ? ASCII_ADVANCE : int'(glyph_size) + WIDE_EXTRA;
        if (int'(cur_x) + advance > int'(right_limit))
        begin
            advance_line();
            if (box_overflow())
            begin
                layout_halted = 1'b1;
                return;
            end
        end
        top = cur_y;
        if (printable && glyph_size >= ASCII_BASE)
            top = clamp_coord(int'(cur_y) + (int'(glyph_size) - ASCII_BASE) / 2);
        if (printable)
            glyph_kind = KIND_ASCII;
        else
            glyph_kind = KIND_WIDE;
        byte_results.push_back('{kind: glyph_kind, code_point: cp, pos_x: cur_x,
                                 pos_y: top, last_of_run: 1'b0});
        cur_x = clamp_coord(int'(cur_x) + advance);
    endtask

    task automatic predict_byte(input logic [BYTE_WIDTH-1:0] octet, input logic last);
        byte_results.delete();
        if (cont_left == 2'd0)
        begin
            if (!octet[7])
                place_char(cp_t'(octet));
            else if (octet[7:5] == 3'b110)
            begin
                cont_left = 2'd1;
                cp_accum  = cp_t'(octet[4:0]);
            end
            else if (octet[7:4] == 4'b1110)
            begin
                cont_left = 2'd2;
                cp_accum  = cp_t'(octet[3:0]);
            end
            else if (octet[7:3] == 5'b11110)
            begin
                cont_left = 2'd3;
                cp_accum  = cp_t'(octet[2:0]);
            end
            else
                place_char(CP_QUESTION);
        end
        else if (octet[7:6] != 2'b10)
        begin
            cont_left = 2'd0;
            cp_accum  = '0;
            place_char(CP_QUESTION);
        end
        else
        begin
            cp_accum  = {cp_accum[CP_WIDTH-7:0], octet[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
            begin
                place_char(cp_accum);
                cp_accum = '0;
            end
        end

        if (last)
        begin
            if (cont_left != 2'd0)
                place_char(CP_QUESTION);
            byte_results.push_back('{kind: KIND_END, code_point: '0, pos_x: '0,
                                     pos_y: clamp_coord(int'(cur_y) + int'(glyph_size)),
                                     last_of_run: 1'b0});
            cont_left     = 2'd0;
            cp_accum      = '0;
            cur_x         = left_edge;
            cur_y         = top_edge;
            layout_halted = 1'b0;
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        foreach (byte_results[i])
            expected_glyphs.push_back(byte_results[i]);
    endtask

    task automatic report_field(input string field, input logic [CP_WIDTH-1:0] want,
                                input logic [CP_WIDTH-1:0] got);
        $display("%0t: glyph %s mismatch, expected 'h%0h, actual 'h%0h",
                 $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_edge     = '0;
            top_edge      = '0;
            right_limit   = coord_t'(COORD_TOP);
            bottom_limit  = coord_t'(COORD_TOP);
            glyph_size    = font_t'(FONT_RESET);
            cont_left     = 2'd0;
            cp_accum      = '0;
            cur_x         = '0;
            cur_y         = '0;
            layout_halted = 1'b0;
            expected_glyphs.delete();
            fail_count    = 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_START_X:
                    begin
                        left_edge = cfg_wr_data;
                        cur_x     = cfg_wr_data;
                    end
                    REG_START_Y:
                    begin
                        top_edge = cfg_wr_data;
                        cur_y    = cfg_wr_data;
                    end
                    REG_MAX_X:     right_limit  = cfg_wr_data;
                    REG_MAX_Y:     bottom_limit = cfg_wr_data;
                    REG_FONT_SIZE: glyph_size   = cfg_wr_data[FONT_WIDTH-1:0];
                    default: ;
                endcase
            end

            if (glyph.valid && glyph.ready)
            begin
                seen = '{kind: glyph.kind, code_point: glyph.code_point, pos_x: glyph.pos_x,
                         pos_y: glyph.pos_y, last_of_run: glyph.last_of_run};
                if (expected_glyphs.size() == 0)
                begin
                    $display("%0t: unexpected glyph, expected none, actual %p", $time, seen);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = expected_glyphs.pop_front();
                    if (seen !== oldest)
                    begin
                        fail_count = fail_count + 1;
                        if (seen.kind !== oldest.kind)
                            report_field("kind", CP_WIDTH'(oldest.kind),
                                         CP_WIDTH'(seen.kind));
                        if (seen.code_point !== oldest.code_point)
                            report_field("code_point", oldest.code_point, seen.code_point);
                        if (seen.pos_x !== oldest.pos_x)
                            report_field("pos_x", CP_WIDTH'(oldest.pos_x),
                                         CP_WIDTH'(seen.pos_x));
                        if (seen.pos_y !== oldest.pos_y)
                            report_field("pos_y", CP_WIDTH'(oldest.pos_y),
                                         CP_WIDTH'(seen.pos_y));
                        if (seen.last_of_run !== oldest.last_of_run)
                            report_field("last_of_run", CP_WIDTH'(oldest.last_of_run),
                                         CP_WIDTH'(seen.last_of_run));
                    end
                end
            end

            if (text.valid && text.ready)
                predict_byte(text.text_byte, text.final_byte);

            pending_results <= expected_glyphs.size();
        end
    end

endmodule

>>> bench/tb_utf8_decode_text_wrap_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf8_decode_text_wrap_top
// Drives UTF-8 text into the text wrap block under a series of box settings:
// a directed text with the corner cases of the decoder, then random texts of
// mostly well-formed characters mixed with broken sequences. Both channels
// pause at random between requests; the checker judges every glyph request.
// ----------------------------------------------------------------------------
module tb_utf8_decode_text_wrap_top;
    import u8wrap_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int TEXT_BYTES   = 1600;
    localparam int DRAIN_CYCLES = 8;
    localparam int COORD_TOP    = (1 << COORD_WIDTH) - 1;

    typedef enum int {
        BOX_FULL_SCREEN,
        BOX_CORNER,
        BOX_EMPTY,
        BOX_RIGHT_EDGE,
        BOX_SMALL,
        BOX_RANDOM
    } box_shape_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [COORD_WIDTH-1:0] cfg_wr_data;
    int unsigned            fail_count;
    int unsigned            pending_results;
    int unsigned            cycle_count = 0;
    bit                     tx_burst = 1'b0;
    bit                     rx_burst = 1'b0;
    logic [BYTE_WIDTH-1:0]  text_buf [$];

    u8wrap_text_if  text_ch ();
    u8wrap_glyph_if glyph_ch ();

    utf8_decode_text_wrap_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .text        (text_ch),
        .glyph       (glyph_ch)
    );

    glyph_layout_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .text            (text_ch),
        .glyph           (glyph_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [BYTE_WIDTH-1:0] lead_for(input int unsigned conts);
        case (conts)
            1:       return {3'b110, 5'($urandom)};
            2:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [BYTE_WIDTH-1:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic append_char();
        int unsigned           sel;
        int unsigned           conts;
        logic [BYTE_WIDTH-1:0] noise;
        sel   = $urandom_range(0, 99);
        conts = $urandom_range(1, 3);
        noise = 8'($urandom);
        if (sel < 30)
            text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        else if (sel < 40)
            text_buf.push_back(CP_NEWLINE[BYTE_WIDTH-1:0]);
        else if (sel < 44)
            text_buf.push_back({1'b0, 7'($urandom)});
        else if (sel < 72)
        begin
            text_buf.push_back(lead_for(conts));
            repeat (conts) text_buf.push_back(cont_byte());
        end
        else if (sel < 80)
            text_buf.push_back(noise);
        else
        begin
            text_buf.push_back(lead_for(conts));
            repeat ($urandom_range(0, conts - 1)) text_buf.push_back(cont_byte());
            if (sel >= 90)
            begin
                if (noise[7:6] == 2'b10)
                    noise[6] = 1'b1;
                text_buf.push_back(noise);
            end
        end
    endtask

    task automatic send_byte(input logic [BYTE_WIDTH-1:0] value, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid      <= 1'b1;
        text_ch.text_byte  <= value;
        text_ch.final_byte <= last;
        do @(posedge clk); while (!text_ch.ready);
    endtask

    task automatic send_text();
        foreach (text_buf[i])
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_ch.valid <= 1'b0;
        text_buf.delete();
    endtask

    task automatic wait_idle();
        do @(posedge clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value[COORD_WIDTH-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input box_shape_t shape);
        int unsigned sx, sy, mx, my, fs;
        case ($urandom_range(0, 2))
            0:       fs = 8;
            1:       fs = 64;
            default: fs = $urandom_range(8, 64);
        endcase
        case (shape)
            BOX_FULL_SCREEN:
            begin
                sx = 0;
                sy = 0;
                mx = COORD_TOP;
                my = COORD_TOP;
            end
            BOX_CORNER:
            begin
                sx = COORD_TOP;
                sy = COORD_TOP;
                mx = COORD_TOP;
                my = COORD_TOP;
            end
            BOX_EMPTY:
            begin
                sx = 0;
                sy = 0;
                mx = 0;
                my = 0;
            end
            BOX_RIGHT_EDGE:
            begin
                sx = $urandom_range(COORD_TOP - 20, COORD_TOP);
                sy = $urandom_range(1700, COORD_TOP);
                mx = COORD_TOP;
                my = COORD_TOP;
            end
            BOX_SMALL:
            begin
                sx = $urandom_range(0, 300);
                sy = $urandom_range(0, 300);
                mx = sx + $urandom_range(0, 120);
                my = sy + $urandom_range(0, 150);
            end
            default:
            begin
                sx = $urandom_range(0, COORD_TOP);
                sy = $urandom_range(0, COORD_TOP);
                mx = $urandom_range(0, COORD_TOP);
                my = $urandom_range(0, COORD_TOP);
            end
        endcase
        wait_idle();
        write_reg(REG_MAX_X, mx);
        write_reg(REG_MAX_Y, my);
        write_reg(REG_FONT_SIZE, fs);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned phase;
        int unsigned pick;
        box_shape_t  shape;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_START_X;
        cfg_wr_data        = '0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.final_byte = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Printable edges, control codes, newline, two to four byte characters,
        // bad lead bytes, stray continuation bytes, an ASCII byte swallowed by a broken
        // sequence, an overlong newline and a sequence cut off by the end of the text.
        text_buf = '{8'h41, 8'h20, 8'h7E, 8'h00, 8'h7F, 8'h0A, 8'hC3, 8'hA9, 8'hE2,
                     8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hBF, 8'hF8,
                     8'hFF, 8'hC3, 8'h41, 8'hC0, 8'h8A, 8'hE2, 8'h82};
        send_text();

        sent  = 0;
        phase = 0;
        while (sent < TEXT_BYTES)
        begin
            if (phase <= BOX_SMALL || $urandom_range(0, 1) == 0)
            begin
                pick = $urandom_range(0, 9);
                if (phase <= BOX_SMALL)
                    shape = box_shape_t'(phase);
                else if (pick < 5)
                    shape = BOX_SMALL;
                else if (pick < 7)
                    shape = BOX_RANDOM;
                else
                    shape = box_shape_t'($urandom_range(BOX_FULL_SCREEN, BOX_RIGHT_EDGE));
                configure(shape);
            end
            phase = phase + 1;
            repeat ($urandom_range(1, 30)) append_char();
            sent     = sent + text_buf.size();
            tx_burst = ($urandom_range(0, 3) == 0);
            send_text();
        end

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        glyph_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                glyph_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            glyph_ch.ready <= 1'b1;
            do @(posedge clk); while (!glyph_ch.valid);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
        end
    end

endmodule
